[design/mbb_pkg.sv]
// Shared types, constants and helpers for the monochrome bitmap blit.
// No dependencies; imported by every module of the block.
package mbb_pkg;

	localparam int MAX_SIDE  = 4096;
	localparam int SIDE_W    = 12;
	localparam int COORD_W   = 16;
	localparam int NUM_LANES = 8;
	localparam int LANE_W    = $clog2(NUM_LANES);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W    = 4;
	localparam int MODE_CLIP_BIT = 3;

	localparam int SIDE_LIM = (MAX_SIDE - 1 > (1 << SIDE_W) - 1) ? (1 << SIDE_W) - 1
		: MAX_SIDE - 1;

	typedef logic [SIDE_W-1:0] side_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_ORIGIN,
		CFG_CLIP_MIN,
		CFG_CLIP_MAX
	} cfg_idx_t;

	// Orientation codes, named by the (x, y) terms added to the origin
	typedef enum logic [2:0] {
		ORI_J_I,
		ORI_I_WJ,
		ORI_WJ_HI,
		ORI_HI_J,
		ORI_WJ_I,
		ORI_I_J,
		ORI_J_HI,
		ORI_HI_WJ
	} orient_t;

	typedef struct packed {
		orient_t orient;
		logic    clip_en;
		side_t   w;
		side_t   h;
		coord_t  ox;
		coord_t  oy;
		coord_t  clip_min_x;
		coord_t  clip_min_y;
		coord_t  clip_max_x;
		coord_t  clip_max_y;
	} blit_cfg_t;

	function automatic side_t side_limit(input side_t v);
		side_t lim;
		lim = SIDE_W'(SIDE_LIM);
		return (v > lim) ? lim : v;
	endfunction

endpackage

[design/mono_bitmap_blit_orient_clip.sv]
// Top level of the monochrome bitmap blit with orientation and clipping.
// Depends on mbb_pkg, mbb_lane and mbb_merge.
//
// Usage:
//   Input channel (in_valid / in_stall / data_byte) takes one bitmap byte per request,
//   leftmost pixel in bit 7. Output channel (out_valid / out_stall) gives one pixel per
//   request: pixel_x, pixel_y and last_of_byte on the final pixel of a byte.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes mode, width,
//   height, origin and clip corners; cfg_ready is always high. Write only while idle.
//   Eight lanes handle the eight bits of a byte side by side; a merging register then
//   serialises the kept pixels. A byte passes the first stage, the second stage and
//   the merging register before its first pixel goes out. A byte with kept pixels holds
//   the output register until all have gone out; one with none never enters stage two.
//   Bytes are taken back to back while the output register drains.
//   Reset clears the row and column counters and loads the register defaults (8x8,
//   orientation 0, no clipping, origin 0). While out_stall is high the current pixel
//   holds, and in_stall rises once the two internal stages behind it are full.
module mono_bitmap_blit_orient_clip (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mbb_pkg::coord_t                   pixel_x,
	output mbb_pkg::coord_t                   pixel_y,
	output logic                              last_of_byte,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mbb_pkg::*;

	// configuration registers
	logic [MODE_W-1:0]     mode_q;
	side_t                 width_q;
	side_t                 height_q;
	logic [CFG_DATA_W-1:0] origin_q;
	logic [CFG_DATA_W-1:0] clip_min_q;
	logic [CFG_DATA_W-1:0] clip_max_q;
	blit_cfg_t             cfg;

	// position counters
	side_t col_q;
	side_t row_q;

	logic                 in_go;
	logic [SIDE_W:0]      col_ext;
	logic [SIDE_W:0]      w_ext;
	logic [NUM_LANES-1:0] lane_act;
	logic [NUM_LANES-1:0] bit_mask;
	logic                 row_end;

	logic                 v_s1;
	side_t                col_s1;
	side_t                row_s1;
	logic [NUM_LANES-1:0] mask_s1;

	coord_t [NUM_LANES-1:0] lane_x;
	coord_t [NUM_LANES-1:0] lane_y;
	logic [NUM_LANES-1:0]   lane_keep;

	logic                   v_s2;
	coord_t [NUM_LANES-1:0] x_s2;
	coord_t [NUM_LANES-1:0] y_s2;
	logic [NUM_LANES-1:0]   keep_s2;
	logic                   merge_ready;
	logic                   s2_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			width_q    <= SIDE_W'(7);
			height_q   <= SIDE_W'(7);
			origin_q   <= '0;
			clip_min_q <= '0;
			clip_max_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:     mode_q     <= cfg_data[MODE_W-1:0];
				CFG_WIDTH:    width_q    <= cfg_data[SIDE_W-1:0];
				CFG_HEIGHT:   height_q   <= cfg_data[SIDE_W-1:0];
				CFG_ORIGIN:   origin_q   <= cfg_data;
				CFG_CLIP_MIN: clip_min_q <= cfg_data;
				CFG_CLIP_MAX: clip_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.orient     = orient_t'(mode_q[2:0]);
		cfg.clip_en    = mode_q[MODE_CLIP_BIT];
		cfg.w          = side_limit(width_q);
		cfg.h          = side_limit(height_q);
		cfg.ox         = origin_q[COORD_W-1:0];
		cfg.oy         = origin_q[2*COORD_W-1:COORD_W];
		cfg.clip_min_x = clip_min_q[COORD_W-1:0];
		cfg.clip_min_y = clip_min_q[2*COORD_W-1:COORD_W];
		cfg.clip_max_x = clip_max_q[COORD_W-1:0];
		cfg.clip_max_y = clip_max_q[2*COORD_W-1:COORD_W];
	end

	// front: which bits of this byte fall inside the current row
	always_comb begin
		col_ext = {1'b0, col_q};
		w_ext   = {1'b0, cfg.w};
		for (int k = 0; k < NUM_LANES; k++) begin
			lane_act[k] = (k == 0) || (col_ext + (SIDE_W+1)'(k) <= w_ext);
			bit_mask[k] = lane_act[k] && data_byte[NUM_LANES-1-k];
		end
		row_end = (col_ext + (SIDE_W+1)'(NUM_LANES - 1)) >= w_ext;
	end

	assign s2_free  = !v_s2 || merge_ready;
	assign in_stall = v_s1 && !s2_free;
	assign in_go    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (in_go) begin
				if (row_end) begin
					// drop the rest of the byte, start the next row
					col_q <= '0;
					row_q <= (row_q >= cfg.h) ? '0 : row_q + SIDE_W'(1);
				end else begin
					col_q <= col_q + SIDE_W'(NUM_LANES);
				end
			end
			if (in_go) begin
				v_s1 <= 1'b1;
			end else if (s2_free) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			col_s1  <= col_q;
			row_s1  <= row_q;
			mask_s1 <= bit_mask;
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		mbb_lane u_lane (
			.cfg    (cfg),
			.col    (col_s1),
			.row    (row_s1),
			.offset (LANE_W'(g)),
			.bit_en (mask_s1[g]),
			.px     (lane_x[g]),
			.py     (lane_y[g]),
			.keep   (lane_keep[g])
		);
	end

	// a byte with no kept pixel is dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1 && (|lane_keep);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			x_s2    <= lane_x;
			y_s2    <= lane_y;
			keep_s2 <= lane_keep;
		end
	end

	mbb_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (v_s2),
		.load_x       (x_s2),
		.load_y       (y_s2),
		.load_keep    (keep_s2),
		.load_ready   (merge_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_byte (last_of_byte)
	);

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with empty first stage");
	a_s2_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (keep_s2 != '0))
		else $error("second stage holds a byte with no pixels");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s2_free) |=> (v_s1 && $stable(mask_s1)))
		else $error("first stage changed while blocked");
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(in_go && !row_end) |=> (col_q <= cfg.w))
		else $error("column passed the row end");

endmodule

[design/mbb_lane.sv]
// One pixel lane: orients a bitmap position, adds the origin and applies the clip test.
// Depends on mbb_pkg.
module mbb_lane (
	input  mbb_pkg::blit_cfg_t          cfg,
	input  mbb_pkg::side_t              col,
	input  mbb_pkg::side_t              row,
	input  logic [mbb_pkg::LANE_W-1:0]  offset,
	input  logic                        bit_en,
	output mbb_pkg::coord_t             px,
	output mbb_pkg::coord_t             py,
	output logic                        keep
);
	import mbb_pkg::*;

	side_t  j;
	coord_t jx;
	coord_t ix;
	coord_t wj;
	coord_t hi;
	coord_t dx;
	coord_t dy;
	logic   in_rect;

	always_comb begin
		j  = col + SIDE_W'(offset);
		jx = COORD_W'(j);
		ix = COORD_W'(row);
		wj = COORD_W'(cfg.w) - jx;
		hi = COORD_W'(cfg.h) - ix;
		unique case (cfg.orient)
			ORI_J_I: begin
				dx = jx; dy = ix;
			end
			ORI_I_WJ: begin
				dx = ix; dy = wj;
			end
			ORI_WJ_HI: begin
				dx = wj; dy = hi;
			end
			ORI_HI_J: begin
				dx = hi; dy = jx;
			end
			ORI_WJ_I: begin
				dx = wj; dy = ix;
			end
			ORI_I_J: begin
				dx = ix; dy = jx;
			end
			ORI_J_HI: begin
				dx = jx; dy = hi;
			end
			ORI_HI_WJ: begin
				dx = hi; dy = wj;
			end
			default: begin
				dx = jx; dy = ix;
			end
		endcase
		// wrap modulo 16 bits, compare signed
		px = cfg.ox + dx;
		py = cfg.oy + dy;
		in_rect = (px >= cfg.clip_min_x) && (px <= cfg.clip_max_x) &&
			(py >= cfg.clip_min_y) && (py <= cfg.clip_max_y);
		keep = bit_en && (!cfg.clip_en || in_rect);
	end

endmodule

[design/mbb_merge.sv]
// Merging stage: holds the lane results of one byte and sends the kept pixels out in
// lane order, one per cycle while out_stall is low, flagging the final one. Depends on mbb_pkg.
module mbb_merge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load_valid,
	input  mbb_pkg::coord_t [mbb_pkg::NUM_LANES-1:0] load_x,
	input  mbb_pkg::coord_t [mbb_pkg::NUM_LANES-1:0] load_y,
	input  logic [mbb_pkg::NUM_LANES-1:0]          load_keep,
	output logic                                   load_ready,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output mbb_pkg::coord_t                        pixel_x,
	output mbb_pkg::coord_t                        pixel_y,
	output logic                                   last_of_byte
);
	import mbb_pkg::*;

	coord_t [NUM_LANES-1:0] x_q;
	coord_t [NUM_LANES-1:0] y_q;
	logic [NUM_LANES-1:0]   pend_q;
	logic [NUM_LANES-1:0]   rest;
	logic [LANE_W-1:0]      sel;
	logic                   out_go;
	logic                   load_go;

	always_comb begin
		sel = '0;
		for (int k = NUM_LANES - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				sel = LANE_W'(k);
			end
		end
	end

	assign rest         = pend_q & (pend_q - NUM_LANES'(1));
	assign out_valid    = |pend_q;
	assign pixel_x      = x_q[sel];
	assign pixel_y      = y_q[sel];
	assign last_of_byte = (rest == '0);
	assign out_go       = out_valid && !out_stall;
	assign load_ready   = !out_valid || (out_go && last_of_byte);
	assign load_go      = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load_go) begin
			pend_q <= load_keep;
		end else if (out_go) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_go) begin
			x_q <= load_x;
			y_q <= load_y;
		end
	end

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_go && !last_of_byte) |=> out_valid)
		else $error("merge lost pending pixels");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_go |-> (!out_valid || (out_go && last_of_byte)))
		else $error("merge reloaded while pixels pending");
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_byte) |-> $onehot(pend_q))
		else $error("last flag with several pixels pending");

endmodule
